// ===== rtl/rsaw_pkg.sv =====
// rsaw_pkg: field widths and payload types for the receive sequence ack window
// no dependencies
package rsaw_pkg;

	localparam int SEQ_W  = 16;
	localparam int LAST_W = 16;
	localparam int BITS_W = 32;
	localparam int NUM_W  = 32;

	localparam logic KIND_PACKET = 1'b0;
	localparam logic KIND_REPORT = 1'b1;

	typedef struct packed {
		logic             kind;
		logic [SEQ_W-1:0] seq_number;
	} req_item_t;

	typedef struct packed {
		logic              accepted;
		logic [LAST_W-1:0] report_last;
		logic [BITS_W-1:0] report_bits;
	} rsp_item_t;

endpackage

// ===== rtl/rsaw_req_if.sv =====
// rsaw_req_if: valid/ready channel carrying packet and report requests
// depends on rsaw_pkg
interface rsaw_req_if;
	import rsaw_pkg::*;

	logic             valid;
	logic             ready;
	logic             kind;
	logic [SEQ_W-1:0] seq_number;

	modport source (output valid, output kind, output seq_number, input ready);
	modport sink (input valid, input kind, input seq_number, output ready);

endinterface

// ===== rtl/rsaw_rsp_if.sv =====
// rsaw_rsp_if: valid/ready channel carrying one result beat per request
// depends on rsaw_pkg
interface rsaw_rsp_if;
	import rsaw_pkg::*;

	logic              valid;
	logic              ready;
	logic              accepted;
	logic [LAST_W-1:0] report_last;
	logic [BITS_W-1:0] report_bits;

	modport source (output valid, output accepted, output report_last, output report_bits,
		input ready);
	modport sink (input valid, input accepted, input report_last, input report_bits,
		output ready);

endinterface

// ===== rtl/rsaw_window.sv =====
// rsaw_window: window state, sequence extension, replay check and bitmap update
// depends on rsaw_pkg
module rsaw_window #(
	parameter int WINDOW   = 32,
	parameter int SEQ_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  rsaw_pkg::req_item_t item,
	output rsaw_pkg::rsp_item_t result
);
	import rsaw_pkg::*;

	localparam int SH_W = $clog2(WINDOW + 1);
	localparam logic [NUM_W-1:0] SEQ_RANGE = NUM_W'(1) << SEQ_BITS;
	localparam logic [NUM_W-1:0] SEQ_HALF  = SEQ_RANGE >> 1;
	localparam logic [NUM_W-1:0] SEQ_MASK  = SEQ_RANGE - NUM_W'(1);
	localparam logic signed [NUM_W-1:0] WIN_POS = NUM_W'(WINDOW);
	localparam logic signed [NUM_W-1:0] WIN_NEG = -WIN_POS;
	localparam logic signed [NUM_W-1:0] HALF_POS = SEQ_HALF;
	localparam logic signed [NUM_W-1:0] HALF_NEG = -HALF_POS;

	logic [NUM_W-1:0]        high_base_q;
	logic [NUM_W-1:0]        highest_q;
	logic [WINDOW:0]         map_q;
	logic                    have_any_q;

	logic [NUM_W-1:0]        raw;
	logic [NUM_W-1:0]        cur0;
	logic [NUM_W-1:0]        hs;
	logic [WINDOW:0]         map_cur;
	logic signed [NUM_W-1:0] dif0;
	logic                    fwd_wrap;
	logic                    back_wrap;
	logic [NUM_W-1:0]        cur;
	logic signed [NUM_W-1:0] dif;
	logic [NUM_W-1:0]        neg_dif;
	logic [SH_W-1:0]         amt;
	logic                    ahead;
	logic                    too_old;
	logic                    dup;
	logic                    pkt_ok;
	logic [WINDOW:0]         map_next;
	logic [63:0]             rep_wide;
	logic [NUM_W-1:0]        last_wide;

	always_comb begin
		raw       = NUM_W'(item.seq_number) & SEQ_MASK;
		cur0      = high_base_q + raw;
		hs        = have_any_q ? highest_q : cur0;
		map_cur   = have_any_q ? map_q : '0;
		dif0      = cur0 - hs;
		back_wrap = dif0 > HALF_POS;
		fwd_wrap  = dif0 < HALF_NEG;
		if (back_wrap) begin
			cur = cur0 - SEQ_RANGE;
		end else if (fwd_wrap) begin
			cur = cur0 + SEQ_RANGE;
		end else begin
			cur = cur0;
		end
		dif     = cur - hs;
		neg_dif = -dif;
		too_old = dif < WIN_NEG;
		ahead   = dif > 0;
		amt     = ahead ? dif[SH_W-1:0] : neg_dif[SH_W-1:0];
		dup     = !too_old && !ahead && map_cur[amt];
		pkt_ok  = !too_old && !dup;
		if (ahead) begin
			if (dif > WIN_POS) begin
				map_next = (WINDOW + 1)'(1);
			end else begin
				map_next = (map_cur << amt) | (WINDOW + 1)'(1);
			end
		end else begin
			map_next = map_cur;
			map_next[amt] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_base_q <= SEQ_RANGE;
			highest_q   <= '0;
			map_q       <= '0;
			have_any_q  <= 1'b0;
		end else if (step && item.kind == KIND_PACKET) begin
			have_any_q <= 1'b1;
			if (fwd_wrap) begin
				high_base_q <= high_base_q + SEQ_RANGE;
			end
			if (pkt_ok) begin
				map_q <= map_next;
				if (ahead || !have_any_q) begin
					highest_q <= cur;
				end
			end
		end
	end

	always_comb begin
		rep_wide  = 64'(map_q >> 1);
		last_wide = highest_q & SEQ_MASK;
		if (item.kind == KIND_REPORT) begin
			result.accepted    = 1'b0;
			result.report_last = last_wide[LAST_W-1:0];
			result.report_bits = rep_wide[BITS_W-1:0];
		end else begin
			result.accepted    = pkt_ok;
			result.report_last = '0;
			result.report_bits = '0;
		end
	end

endmodule

// ===== rtl/receive_sequence_ack_window.sv =====
// receive_sequence_ack_window: top level with request register and result register
// depends on rsaw_pkg, rsaw_req_if, rsaw_rsp_if, rsaw_window
//
// Receive side of a selective-ack window for anti-replay. A packet beat carries
// a SEQ_BITS-wide packet number that is extended to 32 bits with wrap detection;
// it is accepted when new and no more than WINDOW behind the highest number seen,
// and marked in a WINDOW+1 bit map anchored there. A report beat returns the low
// bits of the highest number and the map of the WINDOW numbers before it, without
// changing state. Every request yields exactly one result beat. One request is
// taken per cycle while the result side keeps up: a beat waits in the request
// register, the window update and check run on it there, and the result lands
// in the result register, so back-to-back requests stream at full rate.
module receive_sequence_ack_window #(
	parameter int WINDOW   = 32,
	parameter int SEQ_BITS = 16
) (
	input logic   clk,
	input logic   arst_n,
	rsaw_req_if.sink   req,
	rsaw_rsp_if.source rsp
);
	import rsaw_pkg::*;

	logic      valid_s1;
	req_item_t item_s1;
	logic      rsp_valid_q;
	rsp_item_t rsp_q;
	rsp_item_t result;
	logic      adv;
	logic      step;

	assign adv       = !rsp_valid_q || rsp.ready;
	assign step      = valid_s1 && adv;
	assign req.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.valid && req.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1.kind       <= req.kind;
			item_s1.seq_number <= req.seq_number;
		end
	end

	rsaw_window #(
		.WINDOW   (WINDOW),
		.SEQ_BITS (SEQ_BITS)
	) u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (step) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			rsp_q <= result;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.accepted    = rsp_q.accepted;
	assign rsp.report_last = rsp_q.report_last;
	assign rsp.report_bits = rsp_q.report_bits;

endmodule
